// ----- src/afc_pkg.sv -----
// Shared types, constants and arithmetic helpers of the array factor phasor accumulator.
`default_nettype none

package afc_pkg;

  localparam int MAX_ANTENNAS = 128;
  localparam int PHASE_BITS   = 16;

  localparam int POS_W   = 24;
  localparam int REG_W   = 32;
  localparam int P_W     = REG_W + 1;
  localparam int TERM_W  = 40;
  localparam int PL_W    = 16;
  localparam int PH_W    = P_W - PL_W;
  localparam int HI_W    = TERM_W - PL_W;
  localparam int PROD_W  = PH_W + REG_W;
  localparam int ANG_W   = 32;
  localparam int ACC_W   = 22;
  localparam int CNT_W   = 8;
  localparam int Q14_W   = 16;
  localparam int ITEMS_W = $clog2(MAX_ANTENNAS + 1);

  localparam int CORDIC_STEPS     = 18;
  localparam int CORDIC_PER_STAGE = CORDIC_STEPS / 3;
  localparam int STEP_W           = $clog2(CORDIC_STEPS);
  localparam int CW               = 33;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Z  = 3'd5;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic [ANG_W-1:0] ANG_EIGHTH = 32'h2000_0000;

  localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
  localparam logic signed [CW-1:0] Q14_POS      = 33'sd16384;
  localparam logic signed [CW-1:0] Q14_NEG      = -33'sd16384;
  localparam logic signed [CW-1:0] Q14_HALF     = 33'sd32768;

  localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933405, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335086,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41721,     33'sd20860,
    33'sd10430,     33'sd5215
  };

  typedef logic [2:0][REG_W-1:0] reg3_t;
  typedef logic [2:0][POS_W-1:0] pos3_t;

  typedef struct packed {
    logic valid;
    logic en_x;
    logic en_y;
    logic last;
  } item_ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  function automatic cordic_t cordic_step(input cordic_t s, input logic [STEP_W-1:0] idx);
    cordic_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = $signed(s.y) >>> idx;
    dy = $signed(s.x) >>> idx;
    if (!s.z[CW-1]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - ATAN_TURNS[idx];
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + ATAN_TURNS[idx];
    end
    return r;
  endfunction

  function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    t = v + Q14_HALF;
    r = t >>> 16;
    if (r > Q14_POS) begin
      r = Q14_POS;
    end else if (r < Q14_NEG) begin
      r = Q14_NEG;
    end
    return r[Q14_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [Q14_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W + 1 - Q14_W){b[Q14_W-1]}}, b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/afc_phase.sv -----
// Phase pipeline: position offset, dot product with the phase rate, phase extraction.
`default_nettype none

module afc_phase
  import afc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire item_ctl_t             ctl_in,
  input  wire pos3_t                 pos,
  input  wire reg3_t                 rate,
  input  wire reg3_t                 off,
  output item_ctl_t                  ctl_out,
  output logic [PHASE_BITS-1:0]      phase
);

  item_ctl_t ctl_b_r, ctl_c_r, ctl_d_r, ctl_e_r;

  logic [2:0][P_W-1:0]    p_r, p_nxt;
  logic [2:0][TERM_W-1:0] lo_r, lo_nxt;
  logic [2:0][HI_W-1:0]   hi_r, hi_nxt;
  logic [2:0][TERM_W-1:0] t_r, t_nxt;
  logic [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic signed [PROD_W-1:0] prod_lo [3];
  logic signed [PROD_W-1:0] prod_hi [3];
  logic [TERM_W-1:0]      sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = {off[i][REG_W-1], off[i]} +
                 {{(P_W - POS_W){pos[i][POS_W-1]}}, pos[i]};
      prod_lo[i] = $signed({1'b0, p_r[i][PL_W-1:0]}) * $signed(rate[i]);
      prod_hi[i] = $signed(p_r[i][P_W-1:PL_W]) * $signed(rate[i]);
      lo_nxt[i]  = prod_lo[i][TERM_W-1:0];
      hi_nxt[i]  = prod_hi[i][HI_W-1:0];
      t_nxt[i]   = lo_r[i] + {hi_r[i], {PL_W{1'b0}}};
    end
    sum       = t_r[0] + t_r[1] + t_r[2];
    phase_nxt = sum[TERM_W-1 -: PHASE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
    end else if (adv) begin
      ctl_b_r <= ctl_in;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= p_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      t_r     <= t_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign ctl_out = ctl_e_r;
  assign phase   = phase_r;

endmodule

`default_nettype wire

// ----- src/afc_cordic.sv -----
// Pipelined CORDIC: phase to Q1.14 cosine and sine over three rotation stages.
`default_nettype none

module afc_cordic
  import afc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire item_ctl_t                ctl_in,
  input  wire logic [PHASE_BITS-1:0]    phase,
  output item_ctl_t                     ctl_out,
  output logic signed [Q14_W-1:0]       cos_out,
  output logic signed [Q14_W-1:0]       sin_out
);

  item_ctl_t ctl_f_r, ctl_g_r, ctl_h_r, ctl_i_r;
  logic [1:0] q_f_r, q_g_r, q_h_r;
  cordic_t cf_r, cg_r, ch_r;
  cordic_t cf_nxt, cg_nxt, ch_nxt;
  logic [ANG_W-1:0] ang, ang_rnd, res;
  logic [1:0] q_nxt;
  logic signed [Q14_W-1:0] cx, sy;
  logic signed [Q14_W-1:0] cos_r, sin_r, cos_nxt, sin_nxt;

  always_comb begin
    ang     = {phase, {(ANG_W - PHASE_BITS){1'b0}}};
    ang_rnd = ang + ANG_EIGHTH;
    q_nxt   = ang_rnd[ANG_W-1 -: 2];
    res     = ang - {q_nxt, {(ANG_W - 2){1'b0}}};
    cf_nxt.x = CORDIC_START;
    cf_nxt.y = '0;
    cf_nxt.z = {res[ANG_W-1], res};
    for (int i = 0; i < CORDIC_PER_STAGE; i++) begin
      cf_nxt = cordic_step(cf_nxt, STEP_W'(i));
    end
    cg_nxt = cf_r;
    for (int i = 0; i < CORDIC_PER_STAGE; i++) begin
      cg_nxt = cordic_step(cg_nxt, STEP_W'(i + CORDIC_PER_STAGE));
    end
    ch_nxt = cg_r;
    for (int i = 0; i < CORDIC_PER_STAGE; i++) begin
      ch_nxt = cordic_step(ch_nxt, STEP_W'(i + 2 * CORDIC_PER_STAGE));
    end
    cx = to_q14(ch_r.x);
    sy = to_q14(ch_r.y);
    case (q_h_r)
      QUAD_0: begin
        cos_nxt = cx;
        sin_nxt = sy;
      end
      QUAD_1: begin
        cos_nxt = -sy;
        sin_nxt = cx;
      end
      QUAD_2: begin
        cos_nxt = -cx;
        sin_nxt = -sy;
      end
      default: begin
        cos_nxt = sy;
        sin_nxt = -cx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_f_r <= '0;
      ctl_g_r <= '0;
      ctl_h_r <= '0;
      ctl_i_r <= '0;
    end else if (adv) begin
      ctl_f_r <= ctl_in;
      ctl_g_r <= ctl_f_r;
      ctl_h_r <= ctl_g_r;
      ctl_i_r <= ctl_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cf_r  <= cf_nxt;
      cg_r  <= cg_nxt;
      ch_r  <= ch_nxt;
      q_f_r <= q_nxt;
      q_g_r <= q_f_r;
      q_h_r <= q_g_r;
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign ctl_out = ctl_i_r;
  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

`default_nettype wire

// ----- src/array_factor_phasor_accumulator.sv -----
// Top level: antenna phasor accumulator with configuration, pipeline and result register.
//
// Usage:
//   cfg_*  : register writes (index 0..2 phase rate x/y/z, 3..5 field offset x/y/z).
//            Always ready; write only while no antenna is in flight.
//   in_*   : one antenna per request. tdata = pos_x, pos_y, pos_z (24 bit each),
//            tuser = enable_pol_x, enable_pol_y, tlast = last antenna of the field.
//   out_*  : one result per field, sent after the antenna marked tlast.
//            tdata = sum_re_x, sum_im_x, sum_re_y, sum_im_y, count_x, count_y,
//            tuser = overflow.
// Throughput is one antenna per cycle while in_tready is high; ten registered stages
// (input, four for the offset add and dot product, four for the 18-step CORDIC and
// rounding, then the accumulators) lie between the last antenna of a field and its
// result on out_tvalid. Items past the antenna limit are dropped and flag overflow.
// Reset clears the configuration, the sums, the counts and the pipeline.
// While a result waits, antennas keep flowing; only the next tlast item halts
// the pipeline (in_tready low) until the waiting result is taken.
`default_nettype none

module array_factor_phasor_accumulator
  import afc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]      cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [71:0]           in_tdata,   // pos_x, pos_y, pos_z
  input  wire logic [1:0]            in_tuser,   // enable_pol_x, enable_pol_y
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [103:0]               out_tdata,  // sum_re_x, sum_im_x, sum_re_y, sum_im_y,
                                                 // count_x, count_y
  output logic                       out_tuser   // overflow
);

  reg3_t rate_r, off_r;

  item_ctl_t ctl_a_r, ctl_ph, ctl_cs;
  pos3_t pos_a_r;
  logic [PHASE_BITS-1:0] phase;
  logic signed [Q14_W-1:0] cos_v, sin_v;
  logic adv, consume, take;

  logic signed [ACC_W-1:0] acc_re_x_r, acc_im_x_r, acc_re_y_r, acc_im_y_r;
  logic signed [ACC_W-1:0] acc_re_x_nxt, acc_im_x_nxt, acc_re_y_nxt, acc_im_y_nxt;
  logic [CNT_W-1:0] cnt_x_r, cnt_y_r, cnt_x_nxt, cnt_y_nxt;
  logic [ITEMS_W-1:0] items_seen_r, items_seen_nxt;
  logic overflow_r, overflow_nxt;

  logic out_valid_r;
  logic [103:0] out_data_r;
  logic out_user_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
      off_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE_X: rate_r[0] <= cfg_data;
        REG_RATE_Y: rate_r[1] <= cfg_data;
        REG_RATE_Z: rate_r[2] <= cfg_data;
        REG_OFF_X:  off_r[0]  <= cfg_data;
        REG_OFF_Y:  off_r[1]  <= cfg_data;
        REG_OFF_Z:  off_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the whole pipeline only when a second result would overwrite a waiting one
  assign adv       = !(ctl_cs.valid && ctl_cs.last && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign consume   = adv && ctl_cs.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (adv) begin
      ctl_a_r.valid <= in_tvalid;
      ctl_a_r.en_x  <= in_tuser[0];
      ctl_a_r.en_y  <= in_tuser[1];
      ctl_a_r.last  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_a_r[0] <= in_tdata[23:0];
      pos_a_r[1] <= in_tdata[47:24];
      pos_a_r[2] <= in_tdata[71:48];
    end
  end

  afc_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_in  (ctl_a_r),
    .pos     (pos_a_r),
    .rate    (rate_r),
    .off     (off_r),
    .ctl_out (ctl_ph),
    .phase   (phase)
  );

  afc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_in  (ctl_ph),
    .phase   (phase),
    .ctl_out (ctl_cs),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  always_comb begin
    take           = items_seen_r < ITEMS_W'(MAX_ANTENNAS);
    items_seen_nxt = take ? items_seen_r + 1'b1 : items_seen_r;
    overflow_nxt   = overflow_r | !take;
    acc_re_x_nxt   = acc_re_x_r;
    acc_im_x_nxt   = acc_im_x_r;
    acc_re_y_nxt   = acc_re_y_r;
    acc_im_y_nxt   = acc_im_y_r;
    cnt_x_nxt      = cnt_x_r;
    cnt_y_nxt      = cnt_y_r;
    if (take && ctl_cs.en_x) begin
      acc_re_x_nxt = sat_add(acc_re_x_r, cos_v);
      acc_im_x_nxt = sat_add(acc_im_x_r, sin_v);
      if (cnt_x_r != {CNT_W{1'b1}}) begin
        cnt_x_nxt = cnt_x_r + 1'b1;
      end
    end
    if (take && ctl_cs.en_y) begin
      acc_re_y_nxt = sat_add(acc_re_y_r, cos_v);
      acc_im_y_nxt = sat_add(acc_im_y_r, sin_v);
      if (cnt_y_r != {CNT_W{1'b1}}) begin
        cnt_y_nxt = cnt_y_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_x_r   <= '0;
      acc_im_x_r   <= '0;
      acc_re_y_r   <= '0;
      acc_im_y_r   <= '0;
      cnt_x_r      <= '0;
      cnt_y_r      <= '0;
      items_seen_r <= '0;
      overflow_r   <= 1'b0;
    end else if (consume) begin
      if (ctl_cs.last) begin
        acc_re_x_r   <= '0;
        acc_im_x_r   <= '0;
        acc_re_y_r   <= '0;
        acc_im_y_r   <= '0;
        cnt_x_r      <= '0;
        cnt_y_r      <= '0;
        items_seen_r <= '0;
        overflow_r   <= 1'b0;
      end else begin
        acc_re_x_r   <= acc_re_x_nxt;
        acc_im_x_r   <= acc_im_x_nxt;
        acc_re_y_r   <= acc_re_y_nxt;
        acc_im_y_r   <= acc_im_y_nxt;
        cnt_x_r      <= cnt_x_nxt;
        cnt_y_r      <= cnt_y_nxt;
        items_seen_r <= items_seen_nxt;
        overflow_r   <= overflow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume && ctl_cs.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && ctl_cs.last) begin
      out_data_r <= {cnt_y_nxt, cnt_x_nxt, acc_im_y_nxt, acc_re_y_nxt,
                     acc_im_x_nxt, acc_re_x_nxt};
      out_user_r <= overflow_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without a pending result");

  a_count_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ITEMS_W'(cnt_x_r) <= items_seen_r)
    else $error("count_x exceeds items seen");

  a_count_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ITEMS_W'(cnt_y_r) <= items_seen_r)
    else $error("count_y exceeds items seen");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> items_seen_r == ITEMS_W'(MAX_ANTENNAS))
    else $error("overflow flagged before antenna limit");

endmodule

`default_nettype wire
